// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent on this edge implies consequent on the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Antecedent implies consequent on the same edge.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`endif

// ----- design/epmsc_pkg.sv -----
// ---------------------------------------------------------------------------
// epmsc_pkg
// Types and constants of the encoder PID speed controller.
// ---------------------------------------------------------------------------
`default_nettype none

package epmsc_pkg;

    localparam int WORK_W    = 64;   // datapath word of the serial units
    localparam int MUL_B_W   = 28;   // multiplier operand, one bit per cycle
    localparam int DIV_D_W   = 24;   // divisor width
    localparam int DIV_STEPS = WORK_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [MUL_B_W-1:0] RAW_SCALE = 28'd256000000;
    localparam logic [MUL_B_W-1:0] US_PER_S_M = 28'd1000000;
    localparam logic [DIV_D_W-1:0] US_PER_S_D = 24'd1000000;
    localparam logic [DIV_D_W-1:0] FILT_DIV   = 24'd5;

    localparam logic signed [WORK_W-1:0] DERIV_SAT = 64'sd35184372088832;
    localparam logic signed [WORK_W-1:0] SPEED_MAX = 64'sd268435455;
    localparam logic signed [WORK_W-1:0] SPEED_MIN = -64'sd268435456;

    localparam int INTEGRAL_LIMIT_DEF = 65536;
    localparam int BOOST_PWM_MIN_DEF  = 60;
    localparam int BOOST_PWM_MAX_DEF  = 120;
    localparam int START_RAMP_US_DEF  = 500000;
    localparam int RUN_PWM_DEF        = 40;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN   = 3'd0,
        CFG_INTEG_GAIN  = 3'd1,
        CFG_DERIV_GAIN  = 3'd2,
        CFG_TICK_PERIOD = 3'd3,
        CFG_PWM_LIMIT   = 3'd4,
        CFG_PWM_DEADBND = 3'd5,
        CFG_MOVING_THR  = 3'd6,
        CFG_FF_GAIN     = 3'd7
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RAW_MUL,
        ST_RAW_DIV,
        ST_FILT_DIV,
        ST_INT_MUL,
        ST_INT_DIV,
        ST_DER_MUL,
        ST_DER_DIV,
        ST_P_MUL,
        ST_I_MUL,
        ST_D_MUL,
        ST_F_MUL,
        ST_RUN_OUT,
        ST_BOOST_DIV,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ----- design/epmsc_mul.sv -----
// ---------------------------------------------------------------------------
// epmsc_mul
// Bit-serial signed by unsigned multiplier, one multiplier bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module epmsc_mul (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic signed [epmsc_pkg::WORK_W-1:0]   a,
    input  logic        [epmsc_pkg::MUL_B_W-1:0]  b,
    output logic                                  done,
    output logic signed [epmsc_pkg::WORK_W-1:0]   product
);
    import epmsc_pkg::*;

    localparam int CNT_W = $clog2(MUL_B_W);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [WORK_W-1:0]  mcand_reg, mcand_next;
    logic [MUL_B_W-1:0] mplier_reg, mplier_next;
    logic [WORK_W-1:0]  acc_reg, acc_next;
    logic               neg_reg, neg_next;

    always_comb begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        if (start) begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            mcand_next  = a[WORK_W-1] ? $unsigned(-a) : $unsigned(a);
            mplier_next = b;
            acc_next    = '0;
            neg_next    = a[WORK_W-1];
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(MUL_B_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
        neg_reg    <= neg_next;
    end

    assign done    = done_reg;
    assign product = neg_reg ? -$signed(acc_reg) : $signed(acc_reg);

endmodule

`default_nettype wire

// ----- design/epmsc_div.sv -----
// ---------------------------------------------------------------------------
// epmsc_div
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ---------------------------------------------------------------------------
`default_nettype none

module epmsc_div (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic signed [epmsc_pkg::WORK_W-1:0]   dividend,
    input  logic        [epmsc_pkg::DIV_D_W-1:0]  divisor,
    output logic                                  done,
    output logic signed [epmsc_pkg::WORK_W-1:0]   quotient
);
    import epmsc_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [WORK_W-1:0]  work_reg, work_next;
    logic [DIV_D_W:0]   rem_reg, rem_next;
    logic [DIV_D_W-1:0] dvs_reg, dvs_next;
    logic               neg_reg, neg_next;
    logic [DIV_D_W:0]   shifted;
    logic               qbit;

    always_comb begin
        shifted = {rem_reg[DIV_D_W-1:0], work_reg[WORK_W-1]};
        qbit    = (shifted >= {1'b0, dvs_reg});
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            work_next = dividend[WORK_W-1] ? $unsigned(-dividend) : $unsigned(dividend);
            rem_next  = '0;
            dvs_next  = divisor;
            neg_next  = dividend[WORK_W-1];
        end else if (busy_reg) begin
            rem_next  = qbit ? (shifted - {1'b0, dvs_reg}) : shifted;
            work_next = {work_reg[WORK_W-2:0], qbit};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        neg_reg  <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(work_reg) : $signed(work_reg);

endmodule

`default_nettype wire

// ----- design/encoder_pid_motor_speed_controller.sv -----
// ---------------------------------------------------------------------------
// encoder_pid_motor_speed_controller
// Quadrature-count PID speed loop with start boost, one motor channel.
// ---------------------------------------------------------------------------
// One item is handled at a time. An encoder edge beat passes through the done
// state into the result register once that register is free. A control tick
// runs a sequencer over one bit-serial multiplier and one restoring divider:
// a manual tick does the raw-speed multiply and divide and the filter divide,
// a boost tick adds the boost divide, a run tick adds the integral and
// derivative multiply-divide pairs, four gain multiplies and the output clamp;
// a zero period skips them all. The input is ready again as the result is
// loaded. The result sits in an output register, so a new beat is taken as
// soon as the sequencer is back in idle, even while the last result waits.
// ---------------------------------------------------------------------------
`default_nettype none

module encoder_pid_motor_speed_controller #(
    parameter int INTEGRAL_LIMIT = epmsc_pkg::INTEGRAL_LIMIT_DEF,
    parameter int BOOST_PWM_MIN  = epmsc_pkg::BOOST_PWM_MIN_DEF,
    parameter int BOOST_PWM_MAX  = epmsc_pkg::BOOST_PWM_MAX_DEF,
    parameter int START_RAMP_US  = epmsc_pkg::START_RAMP_US_DEF,
    parameter int RUN_PWM        = epmsc_pkg::RUN_PWM_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // configuration
    input  logic                                    cfg_we,
    input  logic [epmsc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [epmsc_pkg::CFG_DATA_W-1:0]        cfg_data,
    // input beats
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic                                    s_op,
    input  logic                                    s_enc_a,
    input  logic                                    s_enc_b,
    input  logic signed [28:0]                      s_target_speed,
    input  logic                                    s_manual_mode,
    input  logic signed [12:0]                      s_manual_pwm,
    // result beats
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [12:0]                      m_pwm_signed,
    output logic [11:0]                             m_duty,
    output logic                                    m_drive_forward,
    output logic                                    m_drive_backward,
    output logic signed [31:0]                      m_encoder_count,
    output logic signed [28:0]                      m_speed_estimate
);
    import epmsc_pkg::*;

    localparam logic [DIV_D_W-1:0]       RAMP     = DIV_D_W'(START_RAMP_US);
    localparam logic [WORK_W-1:0]        SP_LO    = WORK_W'(BOOST_PWM_MIN);
    localparam logic [WORK_W-1:0]        SP_HI    = WORK_W'(BOOST_PWM_MAX);
    localparam logic signed [WORK_W-1:0] INT_LIM  = WORK_W'(INTEGRAL_LIMIT);
    localparam logic signed [WORK_W-1:0] RUN_BIAS = WORK_W'(RUN_PWM) <<< 16;

    // clamp to +-limit, then force small magnitudes to zero
    function automatic logic signed [12:0] drive_pwm(
        input logic signed [13:0] req,
        input logic [11:0]        lim,
        input logic [11:0]        db
    );
        logic signed [13:0] lims;
        logic signed [13:0] v;
        logic signed [13:0] mag;
        lims = $signed({2'b00, lim});
        if (req > lims)
            v = lims;
        else if (req < -lims)
            v = -lims;
        else
            v = req;
        mag = v[13] ? -v : v;
        if (mag < $signed({2'b00, db}))
            v = '0;
        return v[12:0];
    endfunction

    function automatic logic signed [WORK_W-1:0] sext32(input logic signed [31:0] v);
        return {{(WORK_W-32){v[31]}}, v};
    endfunction

    // config registers
    logic [15:0] prop_gain_reg, prop_gain_next;
    logic [15:0] integ_gain_reg, integ_gain_next;
    logic [15:0] deriv_gain_reg, deriv_gain_next;
    logic [19:0] period_reg, period_next;
    logic [11:0] pwm_limit_reg, pwm_limit_next;
    logic [11:0] deadband_reg, deadband_next;
    logic [23:0] moving_thr_reg, moving_thr_next;
    logic [15:0] ff_gain_reg, ff_gain_next;

    // loop state
    state_t             state_reg, state_next;
    logic signed [31:0] pos_reg, pos_next;
    logic signed [31:0] last_tick_reg, last_tick_next;
    logic signed [28:0] filt_reg, filt_next;
    logic signed [31:0] integ_reg, integ_next;
    logic signed [29:0] last_err_reg, last_err_next;
    logic [23:0]        boost_reg, boost_next;
    logic signed [28:0] last_target_reg, last_target_next;
    logic signed [12:0] applied_reg, applied_next;

    // per-tick working registers
    logic signed [28:0]       target_reg, target_next;
    logic                     manual_reg, manual_next;
    logic signed [29:0]       err_reg, err_next;
    logic signed [46:0]       deriv_reg, deriv_next;
    logic signed [WORK_W-1:0] acc_reg, acc_next;

    // result register
    logic               m_valid_reg, m_valid_next;
    logic signed [12:0] out_pwm_reg, out_pwm_next;
    logic [11:0]        out_duty_reg, out_duty_next;
    logic               out_fwd_reg, out_fwd_next;
    logic               out_bwd_reg, out_bwd_next;
    logic signed [31:0] out_count_reg, out_count_next;
    logic signed [28:0] out_speed_reg, out_speed_next;

    // serial units
    logic                     mul_start, mul_done;
    logic signed [WORK_W-1:0] mul_a, mul_product;
    logic [MUL_B_W-1:0]       mul_b;
    logic                     div_start, div_done;
    logic signed [WORK_W-1:0] div_n, div_q;
    logic [DIV_D_W-1:0]       div_d;

    logic in_fire;

    assign s_ready = (state_reg == ST_IDLE);
    assign in_fire = s_valid && s_ready;

    epmsc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    epmsc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        logic signed [31:0]       delta;
        logic signed [WORK_W-1:0] filt64;
        logic signed [WORK_W-1:0] fsat;
        logic signed [28:0]       fnew;
        logic signed [29:0]       err;
        logic signed [29:0]       fmag;
        logic                     moving;
        logic [24:0]              bt_sum;
        logic [23:0]              bt;
        logic [23:0]              bmin;
        logic signed [WORK_W-1:0] isum;
        logic signed [30:0]       ediff;
        logic signed [WORK_W-1:0] t64;
        logic signed [WORK_W-1:0] ff;
        logic signed [WORK_W-1:0] lim64;
        logic signed [WORK_W-1:0] accc;
        logic signed [WORK_W-1:0] accq;
        logic signed [13:0]       sp;

        delta  = pos_reg - last_tick_reg;
        filt64 = {{(WORK_W-29){filt_reg[28]}}, filt_reg};
        fsat   = '0;
        fnew   = '0;
        err    = '0;
        fmag   = '0;
        moving = 1'b0;
        bt_sum = '0;
        bt     = '0;
        bmin   = '0;
        isum   = '0;
        ediff  = '0;
        t64    = {{(WORK_W-29){target_reg[28]}}, target_reg};
        ff     = '0;
        lim64  = $signed({{(WORK_W-12){1'b0}}, pwm_limit_reg}) <<< 16;
        accc   = '0;
        accq   = '0;
        sp     = '0;

        prop_gain_next  = prop_gain_reg;
        integ_gain_next = integ_gain_reg;
        deriv_gain_next = deriv_gain_reg;
        period_next     = period_reg;
        pwm_limit_next  = pwm_limit_reg;
        deadband_next   = deadband_reg;
        moving_thr_next = moving_thr_reg;
        ff_gain_next    = ff_gain_reg;

        state_next       = state_reg;
        pos_next         = pos_reg;
        last_tick_next   = last_tick_reg;
        filt_next        = filt_reg;
        integ_next       = integ_reg;
        last_err_next    = last_err_reg;
        boost_next       = boost_reg;
        last_target_next = last_target_reg;
        applied_next     = applied_reg;
        target_next      = target_reg;
        manual_next      = manual_reg;
        err_next         = err_reg;
        deriv_next       = deriv_reg;
        acc_next         = acc_reg;

        m_valid_next   = m_valid_reg && !m_ready;
        out_pwm_next   = out_pwm_reg;
        out_duty_next  = out_duty_reg;
        out_fwd_next   = out_fwd_reg;
        out_bwd_next   = out_bwd_reg;
        out_count_next = out_count_reg;
        out_speed_next = out_speed_reg;

        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_n     = '0;
        div_d     = '0;

        if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_PROP_GAIN:   prop_gain_next  = cfg_data[15:0];
                CFG_INTEG_GAIN:  integ_gain_next = cfg_data[15:0];
                CFG_DERIV_GAIN:  deriv_gain_next = cfg_data[15:0];
                CFG_TICK_PERIOD: period_next     = cfg_data[19:0];
                CFG_PWM_LIMIT:   pwm_limit_next  = cfg_data[11:0];
                CFG_PWM_DEADBND: deadband_next   = cfg_data[11:0];
                CFG_MOVING_THR:  moving_thr_next = cfg_data[23:0];
                CFG_FF_GAIN:     ff_gain_next    = cfg_data[15:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (!s_op) begin
                        pos_next   = (s_enc_a == s_enc_b) ? pos_reg + 32'sd1 : pos_reg - 32'sd1;
                        state_next = ST_DONE;
                    end else begin
                        target_next = s_target_speed;
                        manual_next = s_manual_mode;
                        if (s_manual_mode) begin
                            applied_next = drive_pwm({s_manual_pwm[12], s_manual_pwm},
                                                     pwm_limit_reg, deadband_reg);
                        end else if (s_target_speed != last_target_reg) begin
                            boost_next       = '0;
                            last_target_next = s_target_speed;
                        end
                        last_tick_next = pos_reg;
                        if (period_reg == '0) begin
                            state_next = ST_DONE;
                        end else begin
                            mul_start  = 1'b1;
                            mul_a      = sext32(delta);
                            mul_b      = RAW_SCALE;
                            state_next = ST_RAW_MUL;
                        end
                    end
                end
            end
            ST_RAW_MUL: begin
                if (mul_done) begin
                    div_start  = 1'b1;
                    div_n      = mul_product;
                    div_d      = {4'b0, period_reg};
                    state_next = ST_RAW_DIV;
                end
            end
            ST_RAW_DIV: begin
                // 0.6 / 0.4 smoothing as (3*old + 2*raw) / 5
                if (div_done) begin
                    div_start  = 1'b1;
                    div_n      = filt64 + (filt64 <<< 1) + (div_q <<< 1);
                    div_d      = FILT_DIV;
                    state_next = ST_FILT_DIV;
                end
            end
            ST_FILT_DIV: begin
                if (div_done) begin
                    if (div_q > SPEED_MAX)
                        fsat = SPEED_MAX;
                    else if (div_q < SPEED_MIN)
                        fsat = SPEED_MIN;
                    else
                        fsat = div_q;
                    fnew      = fsat[28:0];
                    filt_next = fnew;
                    err       = {target_reg[28], target_reg} - {fnew[28], fnew};
                    fmag      = fnew[28] ? -{fnew[28], fnew} : {fnew[28], fnew};
                    moving    = (fmag >= $signed({6'b0, moving_thr_reg}));
                    err_next  = err;
                    if (manual_reg) begin
                        state_next = ST_DONE;
                    end else if (target_reg == '0) begin
                        integ_next    = '0;
                        last_err_next = '0;
                        boost_next    = '0;
                        applied_next  = '0;
                        state_next    = ST_DONE;
                    end else if (moving) begin
                        mul_start  = 1'b1;
                        mul_a      = {{(WORK_W-30){err[29]}}, err};
                        mul_b      = {8'b0, period_reg};
                        state_next = ST_INT_MUL;
                    end else begin
                        // start boost: ramp from BOOST_PWM_MIN to BOOST_PWM_MAX
                        bt_sum        = {1'b0, boost_reg} + {5'b0, period_reg};
                        bt            = bt_sum[24] ? 24'hFFFFFF : bt_sum[23:0];
                        boost_next    = bt;
                        last_err_next = err;
                        bmin          = (bt < RAMP) ? bt : RAMP;
                        div_start     = 1'b1;
                        div_n         = $signed(SP_LO * {40'b0, RAMP - bmin}
                                                + SP_HI * {40'b0, bmin});
                        div_d         = RAMP;
                        state_next    = ST_BOOST_DIV;
                    end
                end
            end
            ST_INT_MUL: begin
                if (mul_done) begin
                    div_start  = 1'b1;
                    div_n      = mul_product;
                    div_d      = US_PER_S_D;
                    state_next = ST_INT_DIV;
                end
            end
            ST_INT_DIV: begin
                if (div_done) begin
                    isum = sext32(integ_reg) + div_q;
                    if (isum > INT_LIM)
                        isum = INT_LIM;
                    else if (isum < -INT_LIM)
                        isum = -INT_LIM;
                    integ_next = isum[31:0];
                    ediff      = {err_reg[29], err_reg} - {last_err_reg[29], last_err_reg};
                    mul_start  = 1'b1;
                    mul_a      = {{(WORK_W-31){ediff[30]}}, ediff};
                    mul_b      = US_PER_S_M;
                    state_next = ST_DER_MUL;
                end
            end
            ST_DER_MUL: begin
                if (mul_done) begin
                    div_start  = 1'b1;
                    div_n      = mul_product;
                    div_d      = {4'b0, period_reg};
                    state_next = ST_DER_DIV;
                end
            end
            ST_DER_DIV: begin
                if (div_done) begin
                    if (div_q > DERIV_SAT)
                        deriv_next = DERIV_SAT[46:0];
                    else if (div_q < -DERIV_SAT)
                        deriv_next = -DERIV_SAT[46:0];
                    else
                        deriv_next = div_q[46:0];
                    last_err_next = err_reg;
                    acc_next      = '0;
                    mul_start     = 1'b1;
                    mul_a         = {{(WORK_W-30){err_reg[29]}}, err_reg};
                    mul_b         = {12'b0, prop_gain_reg};
                    state_next    = ST_P_MUL;
                end
            end
            ST_P_MUL: begin
                if (mul_done) begin
                    acc_next   = acc_reg + mul_product;
                    mul_start  = 1'b1;
                    mul_a      = sext32(integ_reg);
                    mul_b      = {12'b0, integ_gain_reg};
                    state_next = ST_I_MUL;
                end
            end
            ST_I_MUL: begin
                if (mul_done) begin
                    acc_next   = acc_reg + mul_product;
                    mul_start  = 1'b1;
                    mul_a      = {{(WORK_W-47){deriv_reg[46]}}, deriv_reg};
                    mul_b      = {12'b0, deriv_gain_reg};
                    state_next = ST_D_MUL;
                end
            end
            ST_D_MUL: begin
                if (mul_done) begin
                    acc_next   = acc_reg + mul_product;
                    mul_start  = 1'b1;
                    mul_a      = t64[WORK_W-1] ? -t64 : t64;
                    mul_b      = {12'b0, ff_gain_reg};
                    state_next = ST_F_MUL;
                end
            end
            ST_F_MUL: begin
                if (mul_done) begin
                    ff         = RUN_BIAS + mul_product;
                    acc_next   = (target_reg > 29'sd0) ? acc_reg + ff : acc_reg - ff;
                    boost_next = '0;
                    state_next = ST_RUN_OUT;
                end
            end
            ST_RUN_OUT: begin
                // clamp in Q.16, then drop the fraction toward zero
                if (acc_reg > lim64)
                    accc = lim64;
                else if (acc_reg < -lim64)
                    accc = -lim64;
                else
                    accc = acc_reg;
                accq         = accc[WORK_W-1] ? -((-accc) >>> 16) : (accc >>> 16);
                applied_next = drive_pwm(accq[13:0], pwm_limit_reg, deadband_reg);
                state_next   = ST_DONE;
            end
            ST_BOOST_DIV: begin
                if (div_done) begin
                    sp           = (target_reg > 29'sd0) ? div_q[13:0] : -div_q[13:0];
                    applied_next = drive_pwm(sp, pwm_limit_reg, deadband_reg);
                    state_next   = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    out_pwm_next   = applied_reg;
                    out_duty_next  = applied_reg[12] ? 12'(-applied_reg) : applied_reg[11:0];
                    out_fwd_next   = (applied_reg > 13'sd0);
                    out_bwd_next   = applied_reg[12];
                    out_count_next = pos_reg;
                    out_speed_next = filt_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg   <= 16'd256;
            integ_gain_reg  <= '0;
            deriv_gain_reg  <= '0;
            period_reg      <= 20'd10000;
            pwm_limit_reg   <= 12'd255;
            deadband_reg    <= '0;
            moving_thr_reg  <= 24'd2560;
            ff_gain_reg     <= '0;
            state_reg       <= ST_IDLE;
            pos_reg         <= '0;
            last_tick_reg   <= '0;
            filt_reg        <= '0;
            integ_reg       <= '0;
            last_err_reg    <= '0;
            boost_reg       <= '0;
            last_target_reg <= '0;
            applied_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            prop_gain_reg   <= prop_gain_next;
            integ_gain_reg  <= integ_gain_next;
            deriv_gain_reg  <= deriv_gain_next;
            period_reg      <= period_next;
            pwm_limit_reg   <= pwm_limit_next;
            deadband_reg    <= deadband_next;
            moving_thr_reg  <= moving_thr_next;
            ff_gain_reg     <= ff_gain_next;
            state_reg       <= state_next;
            pos_reg         <= pos_next;
            last_tick_reg   <= last_tick_next;
            filt_reg        <= filt_next;
            integ_reg       <= integ_next;
            last_err_reg    <= last_err_next;
            boost_reg       <= boost_next;
            last_target_reg <= last_target_next;
            applied_reg     <= applied_next;
            m_valid_reg     <= m_valid_next;
        end
        target_reg    <= target_next;
        manual_reg    <= manual_next;
        err_reg       <= err_next;
        deriv_reg     <= deriv_next;
        acc_reg       <= acc_next;
        out_pwm_reg   <= out_pwm_next;
        out_duty_reg  <= out_duty_next;
        out_fwd_reg   <= out_fwd_next;
        out_bwd_reg   <= out_bwd_next;
        out_count_reg <= out_count_next;
        out_speed_reg <= out_speed_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_pwm_signed     = out_pwm_reg;
    assign m_duty           = out_duty_reg;
    assign m_drive_forward  = out_fwd_reg;
    assign m_drive_backward = out_bwd_reg;
    assign m_encoder_count  = out_count_reg;
    assign m_speed_estimate = out_speed_reg;

endmodule

`default_nettype wire

// ----- design/epmsc_checker.sv -----
// ---------------------------------------------------------------------------
// epmsc_checker
// Port-level checks of the speed controller, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module epmsc_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_valid,
    input wire        s_ready,
    input wire        m_valid,
    input wire        m_ready,
    input wire [12:0] m_pwm_signed,
    input wire [31:0] m_encoder_count
);
    // one beat in flight: a taken beat closes the input side
    `ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)
    // idle with nothing offered stays ready
    `ASSERT_NEXT(a_idle_stays, aclk, aresetn, s_ready && !s_valid, s_ready)
    // stalled result holds
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_pwm_signed) && $stable(m_encoder_count))
endmodule

bind encoder_pid_motor_speed_controller epmsc_checker u_epmsc_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_pwm_signed    (m_pwm_signed),
    .m_encoder_count (m_encoder_count)
);

`default_nettype wire

// ----- test/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the encoder PID speed controller: a queue-fed
// driver, a result monitor and an in-bench predictor of every result beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import epmsc_pkg::*;

    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // one input beat
    typedef struct {
        logic               op;
        logic               enc_a;
        logic               enc_b;
        logic signed [28:0] target_speed;
        logic               manual_mode;
        logic signed [12:0] manual_pwm;
    } cmd_t;

    // one result beat
    typedef struct {
        logic signed [12:0] pwm_signed;
        logic [11:0]        duty;
        logic               drive_forward;
        logic               drive_backward;
        logic signed [31:0] encoder_count;
        logic signed [28:0] speed_estimate;
    } res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_op = 1'b0, s_enc_a = 1'b0, s_enc_b = 1'b0, s_manual_mode = 1'b0;
    logic signed [28:0] s_target_speed = '0;
    logic signed [12:0] s_manual_pwm = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [12:0] m_pwm_signed;
    logic [11:0] m_duty;
    logic m_drive_forward, m_drive_backward;
    logic signed [31:0] m_encoder_count;
    logic signed [28:0] m_speed_estimate;

    // beat acceptance seen at the rising edge
    logic s_ready_q = 1'b0;

    encoder_pid_motor_speed_controller u_top (.*);

    always #2 aclk = ~aclk;

    // controller model: registers and state
    longint kp, ki, kd, period, lim, dband, mov_thr, kff;
    logic [31:0] pos_cnt, snap_cnt;
    longint filt_spd, integ, prev_err, prev_target, pwm_out, boost_us;

    cmd_t pending_cmds[$];
    res_t expected_results[$];
    int   fail_cnt = 0;
    bit   quiet_run = 1'b0;   // no idling on either side
    bit   hold_off = 1'b0;    // sender waits for the results to drain

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void apply_pwm(longint req);
        longint v;
        v = clip(req, -lim, lim);
        if ((v < 0 ? -v : v) < dband) v = 0;
        pwm_out = v;
    endfunction

    function automatic void model_reset();
        kp = 256; ki = 0; kd = 0; period = 10000;
        lim = 255; dband = 0; mov_thr = 2560; kff = 0;
        pos_cnt = '0; snap_cnt = '0; boost_us = 0;
        filt_spd = 0; integ = 0; prev_err = 0; prev_target = 0; pwm_out = 0;
    endfunction

    function automatic void model_tick(longint tgt, bit man, longint mpwm);
        longint delta, raw, err, deriv, mag, ff, acc, b, sp;
        bit moving, fwd;
        if (man) apply_pwm(mpwm);
        else if (tgt != prev_target) begin
            boost_us = 0;
            prev_target = tgt;
        end
        delta = longint'($signed(pos_cnt - snap_cnt));
        snap_cnt = pos_cnt;
        if (period == 0) return;
        raw = delta * 256000000 / period;
        filt_spd = clip((3 * filt_spd + 2 * raw) / 5, -268435456, 268435455);
        if (man) return;
        if (tgt == 0) begin
            integ = 0; prev_err = 0; boost_us = 0; pwm_out = 0;
            return;
        end
        err = tgt - filt_spd;
        moving = (filt_spd < 0 ? -filt_spd : filt_spd) >= mov_thr;
        if (moving)
            integ = clip(integ + err * period / 1000000,
                         -INTEGRAL_LIMIT_DEF, INTEGRAL_LIMIT_DEF);
        deriv = clip((err - prev_err) * 1000000 / period, -DERIV_SAT, DERIV_SAT);
        prev_err = err;
        fwd = tgt > 0;
        if (!moving) begin
            boost_us = boost_us + period;
            if (boost_us > 64'hFFFFFF) boost_us = 64'hFFFFFF;
            b = boost_us < START_RAMP_US_DEF ? boost_us : START_RAMP_US_DEF;
            sp = (BOOST_PWM_MIN_DEF * (START_RAMP_US_DEF - b) + BOOST_PWM_MAX_DEF * b)
                 / START_RAMP_US_DEF;
            apply_pwm(clip(fwd ? sp : -sp, -lim, lim));
        end else begin
            mag = tgt < 0 ? -tgt : tgt;
            ff = RUN_PWM_DEF * 65536 + kff * mag;
            acc = kp * err + ki * integ + kd * deriv + (fwd ? ff : -ff);
            boost_us = 0;
            acc = clip(acc, -lim * 65536, lim * 65536);
            apply_pwm(acc / 65536);
        end
    endfunction

    // advance the model by one accepted beat and queue the result it implies
    function automatic void predict_result(cmd_t c);
        res_t r;
        if (c.op == OP_EDGE) begin
            if (c.enc_a == c.enc_b) pos_cnt = pos_cnt + 1;
            else pos_cnt = pos_cnt - 1;
        end else
            model_tick(c.target_speed, c.manual_mode, c.manual_pwm);
        r.pwm_signed     = pwm_out[12:0];
        r.duty           = pwm_out < 0 ? 12'(-pwm_out) : 12'(pwm_out);
        r.drive_forward  = pwm_out > 0;
        r.drive_backward = pwm_out < 0;
        r.encoder_count  = pos_cnt;
        r.speed_estimate = filt_spd[28:0];
        expected_results.push_back(r);
    endfunction

    // ---- driver: new beat offered at the falling edge -----------------------
    always @(negedge aclk) begin
        if (aresetn && !(s_valid && !s_ready_q)) begin
            // previous beat (if any) taken on the last rising edge
            if (pending_cmds.size() > 0 && !hold_off
                && (quiet_run || $urandom_range(99) >= 22)) begin
                cmd_t c;
                c = pending_cmds.pop_front();
                s_op <= c.op; s_enc_a <= c.enc_a; s_enc_b <= c.enc_b;
                s_target_speed <= c.target_speed;
                s_manual_mode <= c.manual_mode; s_manual_pwm <= c.manual_pwm;
                s_valid <= 1'b1;
            end else
                s_valid <= 1'b0;
        end
        m_ready <= aresetn && (quiet_run || $urandom_range(99) >= 22);
    end

    always @(posedge aclk) begin
        s_ready_q <= s_valid && s_ready;   // 1 = beat taken this edge
        if (s_valid && s_ready)
            predict_result('{s_op, s_enc_a, s_enc_b, s_target_speed,
                             s_manual_mode, s_manual_pwm});
    end

    // ---- monitor ------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result beat with nothing expected");
                fail_cnt++;
            end else begin
                res_t e;
                e = expected_results.pop_front();
                if (m_pwm_signed !== e.pwm_signed) begin
                    $error("pwm_signed exp %0d got %0d", e.pwm_signed, m_pwm_signed);
                    fail_cnt++;
                end
                if (m_duty !== e.duty) begin
                    $error("duty exp %0d got %0d", e.duty, m_duty);
                    fail_cnt++;
                end
                if (m_drive_forward !== e.drive_forward) begin
                    $error("drive_forward exp %0b got %0b", e.drive_forward,
                           m_drive_forward);
                    fail_cnt++;
                end
                if (m_drive_backward !== e.drive_backward) begin
                    $error("drive_backward exp %0b got %0b", e.drive_backward,
                           m_drive_backward);
                    fail_cnt++;
                end
                if (m_encoder_count !== e.encoder_count) begin
                    $error("encoder_count exp %0d got %0d", e.encoder_count,
                           m_encoder_count);
                    fail_cnt++;
                end
                if (m_speed_estimate !== e.speed_estimate) begin
                    $error("speed_estimate exp %0d got %0d", e.speed_estimate,
                           m_speed_estimate);
                    fail_cnt++;
                end
            end
        end
    end

    // ---- stimulus helpers ---------------------------------------------------
    function automatic cmd_t edge_cmd(bit a, bit b);
        cmd_t c;
        c.op = OP_EDGE; c.enc_a = a; c.enc_b = b;
        c.target_speed = 29'($urandom); c.manual_mode = 1'($urandom_range(1));
        c.manual_pwm = 13'($urandom);
        return c;
    endfunction

    function automatic cmd_t tick_cmd(longint tgt, bit man, longint mpwm);
        cmd_t c;
        c.op = OP_TICK; c.enc_a = 1'($urandom_range(1)); c.enc_b = 1'($urandom_range(1));
        c.target_speed = 29'(tgt); c.manual_mode = man; c.manual_pwm = 13'(mpwm);
        return c;
    endfunction

    // a burst of edges in one direction then a tick, so speed builds up
    function automatic void queue_burst(int n_edges, bit fwd_dir, longint tgt, bit man,
                                         longint mpwm);
        bit a;
        for (int i = 0; i < n_edges; i++) begin
            a = 1'($urandom_range(1));
            pending_cmds.push_back(edge_cmd(a, fwd_dir ? a : ~a));
        end
        pending_cmds.push_back(tick_cmd(tgt, man, mpwm));
    endfunction

    function automatic longint rand_target();
        case ($urandom_range(5))
            0: return 0;
            1: return $signed(29'($urandom));
            2: return longint'($urandom_range(4000)) - 2000;
            default: return longint'($urandom_range(400000)) - 200000;
        endcase
    endfunction

    task automatic write_reg(cfg_idx_t idx, longint val);
        @(negedge aclk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= CFG_DATA_W'(val);
        @(negedge aclk);
        cfg_we <= 1'b0;
        // the model picks the write up at the falling edge after the block takes it
        case (idx)
            CFG_PROP_GAIN:   kp = val & 16'hFFFF;
            CFG_INTEG_GAIN:  ki = val & 16'hFFFF;
            CFG_DERIV_GAIN:  kd = val & 16'hFFFF;
            CFG_TICK_PERIOD: period = val & 20'hFFFFF;
            CFG_PWM_LIMIT:   lim = val & 12'hFFF;
            CFG_PWM_DEADBND: dband = val & 12'hFFF;
            CFG_MOVING_THR:  mov_thr = val & 24'hFFFFFF;
            CFG_FF_GAIN:     kff = val & 16'hFFFF;
            default: ;
        endcase
    endtask

    // wait until the queue is spent and every result is in, then settle
    task automatic drain();
        while (pending_cmds.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (600) @(posedge aclk);
    endtask

    // ---- main sequence ------------------------------------------------------
    initial begin
        model_reset();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes, both ops, manual clamp, zero target
        pending_cmds.push_back(edge_cmd(1'b0, 1'b0));
        pending_cmds.push_back(edge_cmd(1'b1, 1'b1));
        pending_cmds.push_back(edge_cmd(1'b0, 1'b1));
        pending_cmds.push_back(edge_cmd(1'b1, 1'b0));
        pending_cmds.push_back(tick_cmd(0, 1'b1, 4095));
        pending_cmds.push_back(tick_cmd(0, 1'b1, -4096));
        pending_cmds.push_back(tick_cmd(0, 1'b1, 100));
        pending_cmds.push_back(tick_cmd(268435455, 1'b0, 0));
        pending_cmds.push_back(tick_cmd(-268435456, 1'b0, 0));
        pending_cmds.push_back(tick_cmd(0, 1'b0, 0));
        queue_burst(12, 1'b1, 5000, 1'b0, 0);
        queue_burst(12, 1'b1, 5000, 1'b0, 0);
        queue_burst(12, 1'b0, -5000, 1'b0, 0);
        pending_cmds.push_back(tick_cmd(5000, 1'b0, 0));
        drain();

        // phases over register settings; extremes first, zero period among them
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_PROP_GAIN, ph == 0 ? 0 : ph == 1 ? 65535 : $urandom_range(2048));
            write_reg(CFG_INTEG_GAIN, ph == 1 ? 65535 : $urandom_range(1024));
            write_reg(CFG_DERIV_GAIN, ph == 1 ? 65535 : $urandom_range(64));
            write_reg(CFG_TICK_PERIOD, ph == 0 ? 1 : ph == 1 ? 1000000 :
                      ph == 2 ? 0 : $urandom_range(50000, 100));
            write_reg(CFG_PWM_LIMIT, ph == 0 ? 0 : ph == 1 ? 4095 : $urandom_range(4095));
            write_reg(CFG_PWM_DEADBND, ph == 1 ? 4095 : ph == 0 ? 0 : $urandom_range(80));
            write_reg(CFG_MOVING_THR, ph == 0 ? 16777215 : ph == 1 ? 0 :
                      $urandom_range(20000));
            write_reg(CFG_FF_GAIN, ph == 1 ? 65535 : $urandom_range(512));
            quiet_run = (ph == 4);
            for (int k = 0; k < 36; k++) begin
                if ($urandom_range(9) < 7)
                    queue_burst($urandom_range(8), 1'($urandom_range(1)), rand_target(),
                                $urandom_range(7) == 0,
                                longint'($urandom_range(8191)) - 4096);
                else
                    pending_cmds.push_back(tick_cmd(rand_target(), 1'($urandom_range(1)),
                        longint'($urandom_range(8191)) - 4096));
            end
            if (ph == 3) begin
                // sender holds off until all results are back
                while (pending_cmds.size() > 20) @(posedge aclk);
                hold_off = 1'b1;
                while (s_valid || expected_results.size() > 0) @(posedge aclk);
                hold_off = 1'b0;
            end
            drain();
        end

        quiet_run = 1'b0;
        if (fail_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule
